>>> hdl/lbg_pkg.sv
// ----------------------------------------------------------------------------
// Li-ion battery gauge package
// Shared widths, discharge curve, reciprocal constants and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbg_pkg;

    localparam int SAMPLES_PER_READING = 8;

    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 14;
    localparam int PCT_W    = 7;
    localparam int RATIO_W  = 11;
    localparam int Q_FRAC   = 8;

    localparam int LOG_N = $clog2(SAMPLES_PER_READING);
    localparam int CNT_W = (SAMPLES_PER_READING > 1) ? LOG_N : 1;
    localparam int SUM_W = SAMPLE_W + LOG_N;

    // Averaging divides by a multiply with a rounded-up reciprocal. With the shift set
    // to SUM_W + ceil(log2 N) the quotient is exact over the whole sum range.
    localparam int RECIP_K = SUM_W + LOG_N;
    localparam int RECIP_W = SUM_W + 2;
    localparam longint unsigned RECIP_FULL =
        ((longint'(1) << RECIP_K) + longint'(SAMPLES_PER_READING) - 1) /
        longint'(SAMPLES_PER_READING);
    localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(RECIP_FULL);

    localparam logic [MV_W-1:0] MV_MAX = {MV_W{1'b1}};

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [MV_W-1:0]     t_mv;
    typedef logic [PCT_W-1:0]    t_pct;
    typedef logic [RATIO_W-1:0]  t_ratio;

    // Discharge curve, highest point first.
    localparam int CURVE_POINTS = 11;
    localparam int SEG_IDX_W    = $clog2(CURVE_POINTS);
    localparam t_mv CURVE_MV [CURVE_POINTS] = '{
        14'd4200, 14'd4100, 14'd4000, 14'd3900, 14'd3800, 14'd3700,
        14'd3600, 14'd3500, 14'd3400, 14'd3300, 14'd3000
    };
    localparam t_pct CURVE_PCT [CURVE_POINTS] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
        7'd40, 7'd30, 7'd20, 7'd10, 7'd0
    };

    // Upper segments span 100 mV for 10 %, so rounding half up is (d + 5) / 10.
    // The bottom segment spans 300 mV for 10 %, giving (d + 15) / 30.
    // Both divisions are reciprocal multiplies, exact over their input ranges.
    localparam int STEP_BIAS  = 5;
    localparam int STEP_RECIP = 205;
    localparam int STEP_SHIFT = 11;
    localparam int TAIL_BIAS  = 15;
    localparam int TAIL_RECIP = 2185;
    localparam int TAIL_SHIFT = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_THR      = 2'd2;
    localparam int CFG_DATA_W = 14;

    localparam t_ratio RATIO_RESET      = 11'd512;
    localparam t_mv    CHARGE_THR_RESET = 14'd4250;
    localparam t_mv    DEAD_THR_RESET   = 14'd3000;

endpackage

`default_nettype wire

>>> hdl/lbg_accum.sv
// ----------------------------------------------------------------------------
// Sample accumulator
// Sums samples over one group and hands the completed sum to the group register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbg_accum (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_accept,
    input  wire lbg_pkg::t_sample i_sample,
    input  wire               i_adv,
    output logic              o_last,
    output logic              o_valid,
    output lbg_pkg::t_sum     o_sum
);
    import lbg_pkg::*;

    logic [CNT_W-1:0] r_count;
    t_sum             r_sum;
    logic             r_valid;
    t_sum             r_grp_sum;
    t_sum             w_sum_next;

    assign o_last     = (r_count == CNT_W'(SAMPLES_PER_READING - 1));
    assign w_sum_next = r_sum + SUM_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_accept) begin
            if (o_last) begin
                r_count <= '0;
                r_sum   <= '0;
            end else begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= w_sum_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_accept && o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_accept && o_last) begin
            r_grp_sum <= w_sum_next;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_grp_sum;

endmodule

`default_nettype wire

>>> hdl/lbg_avg.sv
// ----------------------------------------------------------------------------
// Group average
// Divides the group sum by the group size through a reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbg_avg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_adv,
    input  wire               i_valid,
    input  wire lbg_pkg::t_sum i_sum,
    output logic              o_valid,
    output lbg_pkg::t_sample  o_avg
);
    import lbg_pkg::*;

    logic [SUM_W+RECIP_W-1:0] w_prod;
    logic                     r_valid;
    t_sample                  r_avg;

    assign w_prod = (SUM_W + RECIP_W)'(i_sum) * (SUM_W + RECIP_W)'(AVG_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_avg <= w_prod[RECIP_K +: SAMPLE_W];
        end
    end

    assign o_valid = r_valid;
    assign o_avg   = r_avg;

endmodule

`default_nettype wire

>>> hdl/lbg_scale.sv
// ----------------------------------------------------------------------------
// Divider scaling
// Multiplies the average by the Q8 divider ratio and saturates the millivolts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbg_scale (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_adv,
    input  wire                  i_valid,
    input  wire lbg_pkg::t_sample i_avg,
    input  wire lbg_pkg::t_ratio i_ratio,
    output logic                 o_valid,
    output lbg_pkg::t_mv         o_mv
);
    import lbg_pkg::*;

    localparam int PROD_W = SAMPLE_W + RATIO_W;
    localparam int FULL_W = PROD_W - Q_FRAC;

    logic [PROD_W-1:0] w_prod;
    logic [FULL_W-1:0] w_full;
    t_mv               w_mv;
    logic              r_valid;
    t_mv               r_mv;

    assign w_prod = PROD_W'(i_avg) * PROD_W'(i_ratio);
    assign w_full = w_prod[PROD_W-1:Q_FRAC];
    assign w_mv   = (w_full > FULL_W'(MV_MAX)) ? MV_MAX : w_full[MV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mv <= w_mv;
        end
    end

    assign o_valid = r_valid;
    assign o_mv    = r_mv;

endmodule

`default_nettype wire

>>> hdl/lbg_soc.sv
// ----------------------------------------------------------------------------
// State of charge and flags
// Interpolates the discharge curve, compares thresholds and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbg_soc (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_adv,
    input  wire              i_valid,
    input  wire lbg_pkg::t_mv i_mv,
    input  wire lbg_pkg::t_mv i_charge_thr,
    input  wire lbg_pkg::t_mv i_dead_thr,
    output logic             o_valid,
    output lbg_pkg::t_mv     o_mv,
    output lbg_pkg::t_pct    o_pct,
    output logic             o_charging,
    output logic             o_dead
);
    import lbg_pkg::*;

    logic [SEG_IDX_W-1:0] w_cnt;
    t_mv                  w_lo_mv;
    t_pct                 w_lo_pct;
    t_mv                  w_diff;
    logic [8:0]           w_d;
    logic [7:0]           w_step_x;
    logic [15:0]          w_step_prod;
    logic [8:0]           w_tail_x;
    logic [20:0]          w_tail_prod;
    logic [3:0]           w_inc;
    t_pct                 w_pct;
    logic                 w_chg;
    logic                 w_dead;
    logic                 r_valid;
    t_mv                  r_mv;
    t_pct                 r_pct;
    logic                 r_chg;
    logic                 r_dead;

    // The count of curve points, the last excepted, at or above the voltage selects the
    // segment; its lower end is the point at that count.
    always_comb begin
        w_cnt = '0;
        for (int k = 0; k < CURVE_POINTS - 1; k++) begin
            if (i_mv <= CURVE_MV[k]) begin
                w_cnt = w_cnt + SEG_IDX_W'(1);
            end
        end
    end

    assign w_lo_mv     = CURVE_MV[w_cnt];
    assign w_lo_pct    = CURVE_PCT[w_cnt];
    assign w_diff      = i_mv - w_lo_mv;
    assign w_d         = w_diff[8:0];
    assign w_step_x    = 8'(w_d) + 8'(STEP_BIAS);
    assign w_step_prod = 16'(w_step_x) * 16'(STEP_RECIP);
    assign w_tail_x    = w_d + 9'(TAIL_BIAS);
    assign w_tail_prod = 21'(w_tail_x) * 21'(TAIL_RECIP);
    assign w_inc       = (w_cnt == SEG_IDX_W'(CURVE_POINTS - 1))
                         ? w_tail_prod[TAIL_SHIFT +: 4]
                         : w_step_prod[STEP_SHIFT +: 4];

    always_comb begin
        priority if (i_mv >= CURVE_MV[0]) begin
            w_pct = CURVE_PCT[0];
        end else if (i_mv <= CURVE_MV[CURVE_POINTS-1]) begin
            w_pct = CURVE_PCT[CURVE_POINTS-1];
        end else begin
            w_pct = w_lo_pct + PCT_W'(w_inc);
        end
    end

    assign w_chg  = (i_mv >= i_charge_thr);
    assign w_dead = (i_mv < i_dead_thr) && !w_chg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mv   <= i_mv;
            r_pct  <= w_pct;
            r_chg  <= w_chg;
            r_dead <= w_dead;
        end
    end

    assign o_valid    = r_valid;
    assign o_mv       = r_mv;
    assign o_pct      = r_pct;
    assign o_charging = r_chg;
    assign o_dead     = r_dead;

endmodule

`default_nettype wire

>>> hdl/liion_battery_gauge_top.sv
// ----------------------------------------------------------------------------
// Li-ion battery gauge: one sample per cycle; a reading every 8 samples.
// A reading passes the group, average, scale and output registers in turn.
// Input stalls only on a group's last sample while the result pipe is full.
// Sync reset clears accumulator and pipe, loads default ratio and thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module liion_battery_gauge_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire lbg_pkg::t_sample            i_sample_mv,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output lbg_pkg::t_mv                     o_battery_mv,
    output lbg_pkg::t_pct                    o_percent,
    output logic                             o_charging,
    output logic                             o_dead,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [lbg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [lbg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lbg_pkg::*;

    t_ratio  r_ratio;
    t_mv     r_charge_thr;
    t_mv     r_dead_thr;

    logic    w_accept;
    logic    w_last;
    logic    w_grp_valid;
    t_sum    w_grp_sum;
    logic    w_avg_valid;
    t_sample w_avg;
    logic    w_mv_valid;
    t_mv     w_mv;
    logic    w_adv_grp;
    logic    w_adv_avg;
    logic    w_adv_mv;
    logic    w_adv_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio      <= RATIO_RESET;
            r_charge_thr <= CHARGE_THR_RESET;
            r_dead_thr   <= DEAD_THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DIVIDER_RATIO: r_ratio      <= i_cfg_data[RATIO_W-1:0];
                CFG_CHARGE_THR:    r_charge_thr <= i_cfg_data[MV_W-1:0];
                CFG_DEAD_THR:      r_dead_thr   <= i_cfg_data[MV_W-1:0];
                default:           ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on in the same cycle.
    assign w_adv_out = !o_out_valid || !i_out_stall;
    assign w_adv_mv  = !w_mv_valid || w_adv_out;
    assign w_adv_avg = !w_avg_valid || w_adv_mv;
    assign w_adv_grp = !w_grp_valid || w_adv_avg;

    assign o_in_stall = w_last && !w_adv_grp;
    assign w_accept   = i_in_valid && !o_in_stall;

    lbg_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_sample (i_sample_mv),
        .i_adv    (w_adv_grp),
        .o_last   (w_last),
        .o_valid  (w_grp_valid),
        .o_sum    (w_grp_sum)
    );

    lbg_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv_avg),
        .i_valid (w_grp_valid),
        .i_sum   (w_grp_sum),
        .o_valid (w_avg_valid),
        .o_avg   (w_avg)
    );

    lbg_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv_mv),
        .i_valid (w_avg_valid),
        .i_avg   (w_avg),
        .i_ratio (r_ratio),
        .o_valid (w_mv_valid),
        .o_mv    (w_mv)
    );

    lbg_soc u_soc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv_out),
        .i_valid      (w_mv_valid),
        .i_mv         (w_mv),
        .i_charge_thr (r_charge_thr),
        .i_dead_thr   (r_dead_thr),
        .o_valid      (o_out_valid),
        .o_mv         (o_battery_mv),
        .o_pct        (o_percent),
        .o_charging   (o_charging),
        .o_dead       (o_dead)
    );

`ifndef SYNTHESIS
    a_stall_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_last)
        else $error("input stalled on a sample that does not complete a group");

    a_group_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> w_grp_valid)
        else $error("completed group sum was not captured");

    a_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_battery_mv >= CURVE_MV[0])) |-> (o_percent == CURVE_PCT[0]))
        else $error("voltage above the curve did not give full charge");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_charging) |-> !o_dead)
        else $error("reading flagged both charging and dead");
`endif

endmodule

`default_nettype wire

>>> verif/tb_liion_battery_gauge_top.sv
// ----------------------------------------------------------------------------
// Li-ion battery gauge testbench
// Streams ADC samples into the gauge under several divider and threshold
// settings, predicts each reading from the averaged, scaled voltage and the
// discharge curve, and checks every reading field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import lbg_pkg::*;

typedef struct packed {
    t_mv  battery_mv;
    t_pct percent;
    logic charging;
    logic dead;
} gauge_reading_t;

class gauge_reading_tracker;
    localparam int REPORT_LIMIT = 10;

    t_ratio         ratio_q8;
    t_mv            charge_mv;
    t_mv            dead_mv;
    int unsigned    group_sum;
    int unsigned    group_len;
    gauge_reading_t readings_due[$];
    int             fail_count;

    function new();
        ratio_q8   = RATIO_RESET;
        charge_mv  = CHARGE_THR_RESET;
        dead_mv    = DEAD_THR_RESET;
        group_sum  = 0;
        group_len  = 0;
        fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_DIVIDER_RATIO: ratio_q8 = data[RATIO_W-1:0];
            CFG_CHARGE_THR:    charge_mv = data;
            CFG_DEAD_THR:      dead_mv = data;
            default: ;
        endcase
    endfunction

    // Linear interpolation between curve points, rounded half up. The bottom
    // segment spans 300 mV, every other one 100 mV, each worth ten percent.
    function t_pct soc_percent(t_mv v);
        int lo_mv;
        int lo_pct;
        int span;
        int num;
        if (v >= 14'd4200) return 7'd100;
        if (v <= 14'd3000) return 7'd0;
        if (v <= 14'd3300) begin
            lo_mv  = 3000;
            lo_pct = 0;
            span   = 300;
        end else begin
            lo_mv  = 3300 + ((int'(v) - 3301) / 100) * 100;
            lo_pct = 10 + (lo_mv - 3300) / 10;
            span   = 100;
        end
        num = (int'(v) - lo_mv) * 10;
        return t_pct'(lo_pct + (2 * num + span) / (2 * span));
    endfunction

    function void take_sample(t_sample s);
        int unsigned    avg;
        int unsigned    scaled;
        gauge_reading_t r;
        group_sum += s;
        group_len++;
        if (group_len < SAMPLES_PER_READING) return;
        avg       = group_sum / SAMPLES_PER_READING;
        group_sum = 0;
        group_len = 0;
        scaled       = (avg * ratio_q8) >> Q_FRAC;
        r.battery_mv = (scaled > MV_MAX) ? MV_MAX : t_mv'(scaled);
        r.percent    = soc_percent(r.battery_mv);
        r.charging   = (r.battery_mv >= charge_mv);
        r.dead       = (r.battery_mv < dead_mv) && !r.charging;
        readings_due.push_back(r);
    endfunction

    function void check_reading(gauge_reading_t got);
        gauge_reading_t want;
        if (readings_due.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected reading: mv=%0d pct=%0d chg=%0b dead=%0b",
                         got.battery_mv, got.percent, got.charging, got.dead);
            return;
        end
        want = readings_due.pop_front();
        if (got.battery_mv !== want.battery_mv || got.percent !== want.percent ||
            got.charging !== want.charging || got.dead !== want.dead) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display({"reading mismatch: expected mv=%0d pct=%0d chg=%0b dead=%0b,",
                          " got mv=%0d pct=%0d chg=%0b dead=%0b"},
                         want.battery_mv, want.percent, want.charging, want.dead,
                         got.battery_mv, got.percent, got.charging, got.dead);
        end
    endfunction

    function int unsigned pending();
        return readings_due.size();
    endfunction
endclass

module tb_liion_battery_gauge_top;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int GROUPS_EACH  = 17;
    localparam int SEGMENTS     = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_sample               i_sample_mv = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic o_in_stall;
    logic o_out_valid;
    t_mv  o_battery_mv;
    t_pct o_percent;
    logic o_charging;
    logic o_dead;
    logic o_cfg_ready;

    gauge_reading_tracker tracker;

    int          tx_idle_pct  = 7;
    int          rx_stall_pct = 81;
    logic        hold_request = 1'b0;
    logic        hold_started = 1'b0;
    int          hold_left    = 0;
    int unsigned cycle_count  = 0;

    liion_battery_gauge_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_mv  (i_sample_mv),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_battery_mv (o_battery_mv),
        .o_percent    (o_percent),
        .o_charging   (o_charging),
        .o_dead       (o_dead),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver back-pressure. A requested hold keeps the output stalled long
    // enough for the result pipe to fill and push back on the sample input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_request && !hold_started) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES - 1;
            i_out_stall  <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_reading(
                gauge_reading_t'({o_battery_mv, o_percent, o_charging, o_dead}));
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[liion_battery_gauge_top] ERROR");
            $finish;
        end
    end

    task automatic send_sample(t_sample s);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_mv <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.take_sample(s);
    endtask

    // One group of samples, mostly aimed at a battery voltage near the curve
    // so that every segment, both ends and the rounding points are reached.
    task automatic send_group(t_ratio ratio);
        int pick;
        int target;
        int centre;
        int spread;
        int v;
        pick = $urandom_range(99);
        if (pick < 12) begin
            centre = 2048;
            spread = 2048;
        end else if (pick < 16) begin
            centre = (pick < 14) ? 0 : 4095;
            spread = 0;
        end else begin
            if (pick < 30)
                target = 3000 + 100 * int'($urandom_range(12)) + int'($urandom_range(2)) - 1;
            else
                target = $urandom_range(4400, 2800);
            centre = (ratio == 0) ? int'($urandom_range(4095)) :
                     (target * 256 + int'(ratio) - 1) / int'(ratio);
            spread = (pick < 60) ? 0 : int'($urandom_range(60));
        end
        for (int k = 0; k < SAMPLES_PER_READING; k++) begin
            v = centre - spread + int'($urandom_range(2 * spread));
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            send_sample(t_sample'(v));
        end
    endtask

    // Registers are only touched once the gauge has gone quiet. The unused
    // index is poked too when poke_unused is set; ratio writes carry junk in spare bits.
    task automatic write_settings(t_ratio ratio, t_mv chg, t_mv dead_thr, bit poke_unused);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        int                    n;
        idx[0] = CFG_UNUSED;
        val[0] = CFG_DATA_W'($urandom);
        idx[1] = CFG_DIVIDER_RATIO;
        val[1] = CFG_DATA_W'($urandom);
        val[1][RATIO_W-1:0] = ratio;
        idx[2] = CFG_CHARGE_THR;
        val[2] = chg;
        idx[3] = CFG_DEAD_THR;
        val[3] = dead_thr;
        n = poke_unused ? 0 : 1;
        for (int k = n; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            tracker.write_reg(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_ratio ratio_sel;
        t_mv    chg_sel;
        t_mv    dead_sel;
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty input, full-scale input, and a truncated
        // average landing exactly on the top of the curve.
        repeat (SAMPLES_PER_READING) send_sample(t_sample'(0));
        repeat (SAMPLES_PER_READING) send_sample(t_sample'(4095));
        repeat (SAMPLES_PER_READING - 1) send_sample(t_sample'(2100));
        send_sample(t_sample'(2107));
        i_in_valid <= 1'b0;
        wait_idle();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: begin ratio_sel = 11'd256;  chg_sel = 14'd4100;  dead_sel = 14'd3300;  end
                1: begin ratio_sel = 11'd1024; chg_sel = 14'd16383; dead_sel = 14'd0;     end
                2: begin ratio_sel = 11'd2047; chg_sel = 14'd0;     dead_sel = 14'd16383; end
                3: begin ratio_sel = 11'd0;    chg_sel = 14'd1;     dead_sel = 14'd16383; end
                4: begin
                    ratio_sel = t_ratio'($urandom_range(1024, 256));
                    chg_sel   = t_mv'($urandom_range(4400, 2800));
                    dead_sel  = t_mv'($urandom_range(4400, 2800));
                end
                default: begin
                    ratio_sel = RATIO_RESET;
                    chg_sel   = CHARGE_THR_RESET;
                    dead_sel  = DEAD_THR_RESET;
                end
            endcase
            write_settings(ratio_sel, chg_sel, dead_sel, (seg % 2) == 1);
            case (seg / 2)
                0: begin tx_idle_pct = 7;  rx_stall_pct = 81; end
                1: begin tx_idle_pct = 81; rx_stall_pct = 7;  end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            if (seg == 4) hold_request = 1'b1;
            repeat (GROUPS_EACH) send_group(ratio_sel);
            i_in_valid <= 1'b0;
            wait_idle();
        end

        if (tracker.fail_count == 0 && tracker.pending() == 0)
            $display("[liion_battery_gauge_top] OK");
        else
            $display("[liion_battery_gauge_top] ERROR");
        $finish;
    end
endmodule
